// ===== hdl/prs_pkg.sv =====
// Shared types and constants for the priority request scheduler.
// Used by priority_request_scheduler and the testbench; depends on nothing.
package prs_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int STAMP_BITS_DEF  = 16;

    localparam int ACT_W    = 2;
    localparam int ID_W     = 10;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;

    localparam int DRAIN_MAX = 16;
    localparam int DRAIN_W   = $clog2(DRAIN_MAX);

    typedef enum logic [ACT_W-1:0] {
        ACT_ARRIVE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_DRAIN  = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

// ===== hdl/prs_entry_ram.sv =====
// Entry memory of the scheduler: one write port and one read port with
// registered read data. Depends on nothing.
module prs_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/priority_request_scheduler.sv =====
// Priority request scheduler top level with its scan sequencer.
// Depends on prs_pkg and prs_entry_ram.
//
// The input channel (i_valid, o_stall) takes one item: an arrival with an id
// and a priority, a tick that serves the least waiting request, or a drain
// that serves up to sixteen waiting requests in order. The output channel
// (o_valid, i_stall) returns the results; o_last marks the final result of
// each item, and an unused action code gives no result.
// An arrival's free slot is found from the used bits and written in the
// accept cycle. A tick or a drain step reads the entry memory once per slot
// through its single read port. Ticks and drains on an empty table skip the
// scan. One item is worked on at a time; the next item is taken while the
// last result still sits in the output register.
// Reset clears the used bits, the tick count and the waiting count; the
// memory contents need no clearing. While the receiver stalls, the output
// register holds its result and the sequencer waits before loading another.
module priority_request_scheduler #(
    parameter int TABLE_DEPTH = prs_pkg::TABLE_DEPTH_DEF,
    parameter int STAMP_BITS  = prs_pkg::STAMP_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [prs_pkg::ACT_W-1:0]     i_action,
    input  logic [prs_pkg::ID_W-1:0]      i_req_id,
    input  logic [prs_pkg::PRIO_W-1:0]    i_priority_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [prs_pkg::ID_W-1:0]      o_served_id,
    output logic                          o_served_valid,
    output logic [prs_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int DW    = prs_pkg::DRAIN_W;
    localparam int KEY_W = prs_pkg::PRIO_W + STAMP_BITS + prs_pkg::ID_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    prs_pkg::t_state r_state, n_state;

    logic [TABLE_DEPTH-1:0]      r_used;
    logic [CW-1:0]               r_count;
    logic [STAMP_BITS-1:0]       r_tick;
    logic                        r_is_drain;
    logic [DW-1:0]               r_drain_n;

    logic [AW-1:0] r_rd_addr;
    logic          r_issuing;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;

    logic             r_best_found;
    logic [KEY_W-1:0] r_best_key;
    logic [AW-1:0]    r_best_idx;

    logic [prs_pkg::ID_W-1:0]     r_res_id;
    logic                         r_res_sv;
    logic [prs_pkg::STATUS_W-1:0] r_res_status;
    logic                         r_res_last;
    logic                         r_more;

    logic                         r_out_valid;
    logic [prs_pkg::ID_W-1:0]     r_out_id;
    logic                         r_out_sv;
    logic [prs_pkg::STATUS_W-1:0] r_out_status;
    logic                         r_out_last;

    logic             in_acc;
    logic             out_free;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    free_idx;
    logic             tbl_full;
    logic [KEY_W-1:0] rd_key;
    logic             cand_better;
    logic             drain_last;

    assign in_acc   = i_valid && (r_state == prs_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign tbl_full = (r_count == CW'(TABLE_DEPTH));
    assign wr_en    = in_acc && (i_action == prs_pkg::ACT_ARRIVE) && !tbl_full;
    assign rd_en    = (r_state == prs_pkg::S_SCAN) && r_issuing;

    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = AW'(i);
            end
        end
    end

    prs_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (free_idx),
        .i_wr_data ({i_priority_req, r_tick, i_req_id}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_key)
    );

    assign cand_better = r_cmp_vld && r_used[r_cmp_idx] &&
                         (!r_best_found || (rd_key < r_best_key));
    assign drain_last  = (r_count == CW'(1)) ||
                         (r_drain_n == DW'(prs_pkg::DRAIN_MAX - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            prs_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        prs_pkg::ACT_ARRIVE: n_state = prs_pkg::S_EMIT;
                        prs_pkg::ACT_TICK, prs_pkg::ACT_DRAIN: begin
                            n_state = (r_count == '0) ? prs_pkg::S_EMIT
                                                      : prs_pkg::S_SCAN;
                        end
                        default: n_state = prs_pkg::S_IDLE;
                    endcase
                end
            end
            prs_pkg::S_SCAN: begin
                if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    n_state = prs_pkg::S_FIN;
                end
            end
            prs_pkg::S_FIN: n_state = prs_pkg::S_EMIT;
            prs_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = r_more ? prs_pkg::S_SCAN : prs_pkg::S_IDLE;
                end
            end
            default: n_state = prs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prs_pkg::S_IDLE;
            r_used      <= '0;
            r_count     <= '0;
            r_tick      <= '0;
            r_issuing   <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            r_cmp_idx <= r_rd_addr;

            if (wr_en) begin
                r_used[free_idx] <= 1'b1;
                r_count          <= r_count + CW'(1);
            end

            if (in_acc && (i_action == prs_pkg::ACT_TICK) && (r_tick != '1)) begin
                r_tick <= r_tick + STAMP_BITS'(1);
            end

            if (n_state == prs_pkg::S_SCAN && r_state != prs_pkg::S_SCAN) begin
                r_rd_addr    <= '0;
                r_issuing    <= 1'b1;
                r_best_found <= 1'b0;
            end else if (rd_en) begin
                if (r_rd_addr == LAST_IDX) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                end
            end

            if (cand_better) begin
                r_best_found <= 1'b1;
                r_best_key   <= rd_key;
                r_best_idx   <= r_cmp_idx;
            end

            if (in_acc) begin
                r_is_drain <= (i_action == prs_pkg::ACT_DRAIN);
                r_drain_n  <= '0;
                r_res_id   <= '0;
                r_res_sv   <= 1'b0;
                r_res_last <= 1'b1;
                r_more     <= 1'b0;
                if (i_action == prs_pkg::ACT_ARRIVE) begin
                    r_res_status <= tbl_full ? prs_pkg::ST_FULL : prs_pkg::ST_OK;
                end else begin
                    r_res_status <= prs_pkg::ST_EMPTY;
                end
            end

            if (r_state == prs_pkg::S_FIN) begin
                r_used[r_best_idx] <= 1'b0;
                r_count            <= r_count - CW'(1);
                r_res_id           <= r_best_key[prs_pkg::ID_W-1:0];
                r_res_sv           <= 1'b1;
                r_res_status       <= prs_pkg::ST_OK;
                r_res_last         <= !r_is_drain || drain_last;
                r_more             <= r_is_drain && !drain_last;
                r_drain_n          <= r_drain_n + DW'(1);
            end

            if (r_state == prs_pkg::S_EMIT && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_id     <= r_res_id;
                r_out_sv     <= r_res_sv;
                r_out_status <= r_res_status;
                r_out_last   <= r_res_last;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall        = (r_state != prs_pkg::S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_served_id    = r_out_id;
    assign o_served_valid = r_out_sv;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for priority_request_scheduler: directed and random
// request traffic runs through a model of the waiting table, checked in order.
// Depends on prs_pkg and priority_request_scheduler.
module testbench;

    localparam int SLOTS = prs_pkg::TABLE_DEPTH_DEF;
    localparam int ACT_W = prs_pkg::ACT_W;
    localparam int ID_W = prs_pkg::ID_W;
    localparam int PRIO_W = prs_pkg::PRIO_W;
    localparam int STATUS_W = prs_pkg::STATUS_W;
    localparam int DRAIN_MAX = prs_pkg::DRAIN_MAX;
    // A narrow stamp lets the tick count reach its top value within a short run.
    localparam int STAMP_W = 7;
    localparam logic [STAMP_W-1:0] STAMP_TOP = '1;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 4 * (SLOTS + 3);

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_request;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic                served;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_service;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [ACT_W-1:0]    i_action = '0;
    logic [ID_W-1:0]     i_req_id = '0;
    logic [PRIO_W-1:0]   i_priority_req = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [ID_W-1:0]     o_served_id;
    logic                o_served_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;

    t_request request_feed[$];
    t_service due_results[$];
    logic     in_fire = 1'b0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       cycle_count = 0;
    int       error_count = 0;

    bit                  occupied [SLOTS];
    logic [ID_W-1:0]     ent_id [SLOTS];
    logic [PRIO_W-1:0]   ent_prio [SLOTS];
    logic [STAMP_W-1:0]  ent_stamp [SLOTS];
    logic [STAMP_W-1:0]  tick_now = '0;

    priority_request_scheduler #(
        .STAMP_BITS (STAMP_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_req_id       (i_req_id),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_served_id    (o_served_id),
        .o_served_valid (o_served_valid),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int least_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (occupied[i] && (best < 0 || ent_prio[i] < ent_prio[best] ||
                (ent_prio[i] == ent_prio[best] && (ent_stamp[i] < ent_stamp[best] ||
                (ent_stamp[i] == ent_stamp[best] && ent_id[i] < ent_id[best])))))
                best = i;
        end
        return best;
    endfunction

    function automatic void add_service(input logic [ID_W-1:0] id, input logic served,
                                        input logic [STATUS_W-1:0] status,
                                        input logic last);
        due_results.insert(due_results.size(), t_service'{id, served, status, last});
    endfunction

    task automatic predict_service(input t_request req);
        int slot;
        int next;
        int n;
        slot = -1;
        if (req.action == prs_pkg::ACT_ARRIVE) begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!occupied[i])
                    slot = i;
            end
            if (slot < 0) begin
                add_service('0, 1'b0, prs_pkg::ST_FULL, 1'b1);
            end else begin
                occupied[slot] = 1'b1;
                ent_id[slot] = req.id;
                ent_prio[slot] = req.prio;
                ent_stamp[slot] = tick_now;
                add_service('0, 1'b0, prs_pkg::ST_OK, 1'b1);
            end
        end else if (req.action == prs_pkg::ACT_TICK) begin
            slot = least_slot();
            if (slot < 0) begin
                add_service('0, 1'b0, prs_pkg::ST_EMPTY, 1'b1);
            end else begin
                occupied[slot] = 1'b0;
                add_service(ent_id[slot], 1'b1, prs_pkg::ST_OK, 1'b1);
            end
            if (tick_now != STAMP_TOP)
                tick_now = tick_now + STAMP_W'(1);
        end else if (req.action == prs_pkg::ACT_DRAIN) begin
            slot = least_slot();
            if (slot < 0)
                add_service('0, 1'b0, prs_pkg::ST_EMPTY, 1'b1);
            n = 0;
            while (slot >= 0 && n < DRAIN_MAX) begin
                occupied[slot] = 1'b0;
                n++;
                next = least_slot();
                add_service(ent_id[slot], 1'b1, prs_pkg::ST_OK,
                            next < 0 || n >= DRAIN_MAX);
                slot = next;
            end
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_service got;
        t_service want;
        cycle_count <= cycle_count + 1;
        in_fire = i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_served_id, o_served_valid, o_status, o_last};
            if (due_results.size() == 0) begin
                $display({"%0t: unexpected result: expected none, ",
                          "actual id %0d valid %0b status %0d last %0b"},
                         $time, got.id, got.served, got.status, got.last);
                error_count++;
            end else begin
                want = due_results.pop_front();
                check_field("served_id", int'(want.id), int'(got.id));
                check_field("served_valid", int'(want.served), int'(got.served));
                check_field("status", int'(want.status), int'(got.status));
                check_field("last", int'(want.last), int'(got.last));
            end
        end
        if (in_fire)
            predict_service('{i_action, i_req_id, i_priority_req});
    end

    always @(negedge i_clk) begin : driver
        t_request item;
        i_stall <= ($urandom_range(99) < stall_pct);
        if (!i_valid || in_fire) begin
            if (i_rst_n && request_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
                item = request_feed.pop_front();
                i_valid <= 1'b1;
                i_action <= item.action;
                i_req_id <= item.id;
                i_priority_req <= item.prio;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    function automatic void post_request(input logic [ACT_W-1:0] act, input int id,
                                         input int prio);
        request_feed.insert(request_feed.size(),
                            t_request'{act, ID_W'(id), PRIO_W'(prio)});
    endfunction

    task automatic wait_quiet();
        while (request_feed.size() != 0 || i_valid || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly bursts of arrivals and ticks, with narrow id and priority ranges
    // now and then so that ties on priority, stamp and id come up often.
    task automatic queue_traffic(input int count);
        int made;
        int pick;
        int burst;
        int id_top;
        int prio_top;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            id_top = ($urandom_range(1) != 0) ? 7 : 1023;
            prio_top = ($urandom_range(1) != 0) ? 3 : 15;
            if (pick < 45) begin
                burst = $urandom_range(20, 1);
                repeat (burst)
                    post_request(prs_pkg::ACT_ARRIVE, $urandom_range(id_top),
                                 $urandom_range(prio_top));
            end else if (pick < 78) begin
                burst = $urandom_range(6, 1);
                repeat (burst)
                    post_request(prs_pkg::ACT_TICK, $urandom_range(1023),
                                 $urandom_range(15));
            end else if (pick < 92) begin
                burst = 1;
                post_request(prs_pkg::ACT_DRAIN, $urandom_range(1023), $urandom_range(15));
            end else begin
                burst = 0;
                post_request(ACT_UNUSED, $urandom_range(1023), $urandom_range(15));
            end
            made += burst;
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct = idle;
        stall_pct = stall;
        queue_traffic(count);
        wait_quiet();
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** priority_request_scheduler: FAILED **");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        post_request(prs_pkg::ACT_DRAIN, 0, 0);
        post_request(prs_pkg::ACT_TICK, 0, 0);
        post_request(ACT_UNUSED, 1023, 15);
        post_request(prs_pkg::ACT_ARRIVE, 1023, 15);
        post_request(prs_pkg::ACT_ARRIVE, 0, 0);
        post_request(prs_pkg::ACT_TICK, 1023, 15);
        post_request(prs_pkg::ACT_ARRIVE, 1, 15);
        post_request(prs_pkg::ACT_ARRIVE, 1, 15);
        for (int k = 0; k < SLOTS - 3; k++)
            post_request(prs_pkg::ACT_ARRIVE, 'h155 ^ k, k % 4);
        post_request(prs_pkg::ACT_ARRIVE, 'h2AA, 0);
        post_request(prs_pkg::ACT_DRAIN, 0, 0);
        wait_quiet();

        run_phase(0, 0, 80);
        run_phase(87, 0, 80);
        run_phase(0, 87, 80);
        run_phase(10, 10, 80);

        // Run the tick count into saturation, then check ordering at the top stamp.
        idle_pct = 0;
        stall_pct = 0;
        repeat (3)
            post_request(prs_pkg::ACT_ARRIVE, $urandom_range(1023), $urandom_range(15));
        repeat (1 << STAMP_W)
            post_request(prs_pkg::ACT_TICK, 0, 0);
        repeat (10)
            post_request(prs_pkg::ACT_ARRIVE, $urandom_range(1023), 2);
        post_request(prs_pkg::ACT_DRAIN, 0, 0);
        wait_quiet();
        run_phase(0, 0, 40);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, due_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** priority_request_scheduler: PASSED **");
        else
            $display("** priority_request_scheduler: FAILED **");
        $finish;
    end

endmodule
